// File: rtl/assert_macros.svh
// Assertion macros for the search unit's RTL; included by the result stage.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Condition must hold on every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, ck, rs, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rs) (cond)) \
        else $error("assertion failed: condition");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ck, rs, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rs) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ck, rs, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rs) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(lbl, ck, rs, cond)
`define ASSERT_SAME(lbl, ck, rs, ante, cons)
`define ASSERT_NEXT(lbl, ck, rs, ante, cons)

`endif

`endif

// File: rtl/mbps_pkg.sv
// Types, constants and helpers of the masked byte pattern search unit.
package mbps_pkg;

    localparam int MAX_PATTERN = 64;
    localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W       = 7;
    localparam int ENTRY_W     = 6;
    localparam int BYTE_W      = 8;
    localparam int ADDR_W      = 32;
    localparam int CFG_ADDR_W  = 4;
    localparam int CFG_DATA_W  = 32;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_STREAM = 1'b1;

    typedef enum logic [1:0] {
        REG_PATTERN_LENGTH  = 2'd0,
        REG_RESULT_OFFSET   = 2'd1,
        REG_SEARCH_BACKWARD = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic               mode;
        logic [ENTRY_W-1:0] entry_index;
        logic [BYTE_W-1:0]  byte_value;
        logic               care;
        logic [ADDR_W-1:0]  byte_address;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } out_item_t;

    // Pattern byte lined up with one window cell
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              cmp;
        logic              en;
    } pat_ent_t;

    // Compare outcome of one streamed byte, handed to the result stage
    typedef struct packed {
        logic              match;
        logic              last;
        logic [ADDR_W-1:0] start;
    } s1_t;

    // Clamp the programmed length into 1..MAX_PATTERN
    function automatic logic [LEN_W-1:0] used_length(input logic [LEN_W-1:0] len);
        if (len == '0)
            return LEN_W'(1);
        if (32'(len) > MAX_PATTERN)
            return LEN_W'(MAX_PATTERN);
        return len;
    endfunction

endpackage

// File: rtl/mbps_if.sv
// Valid/ready channel interfaces for input and result items.
interface mbps_in_if;
    logic                valid;
    logic                ready;
    mbps_pkg::in_item_t  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mbps_out_if;
    logic                valid;
    logic                ready;
    mbps_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/mbps_cell.sv
// One window cell: holds a data byte and compares it with its aligned pattern byte.
module mbps_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            shift,
    input  logic                            clear,
    input  logic [mbps_pkg::BYTE_W-1:0]     byte_in,
    input  logic                            valid_in,
    input  mbps_pkg::pat_ent_t              pat,
    output logic [mbps_pkg::BYTE_W-1:0]     byte_out,
    output logic                            valid_out,
    output logic                            hit
);
    import mbps_pkg::*;

    logic [BYTE_W-1:0] byte_reg;
    logic              valid_reg;

    // Compare the byte arriving in this cycle; unused positions always hit
    assign hit = !pat.en || (valid_in && (!pat.cmp || (byte_in == pat.value)));

    // Advance the byte toward the older end of the window
    always_ff @(posedge clk)
    begin
        if (shift)
            byte_reg <= byte_in;
    end

    // Drop the contents when the range ends
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (shift)
            valid_reg <= clear ? 1'b0 : valid_in;
    end

    assign byte_out  = byte_reg;
    assign valid_out = valid_reg;

endmodule

// File: rtl/mbps_window.sv
// Byte window: the chain of compare cells and the AND of their hits.
module mbps_window (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            shift,
    input  logic                            clear,
    input  logic [mbps_pkg::BYTE_W-1:0]     new_byte,
    input  mbps_pkg::pat_ent_t              pat [mbps_pkg::MAX_PATTERN],
    output logic                            match
);
    import mbps_pkg::*;

    logic [BYTE_W-1:0]      byte_q  [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] valid_q;
    logic [MAX_PATTERN-1:0] hit;

    // Build the chain; cell 0 takes the newest byte
    for (genvar j = 0; j < MAX_PATTERN; j++)
    begin : g_cell
        if (j == 0)
        begin : g_head
            mbps_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift     (shift),
                .clear     (clear),
                .byte_in   (new_byte),
                .valid_in  (1'b1),
                .pat       (pat[j]),
                .byte_out  (byte_q[j]),
                .valid_out (valid_q[j]),
                .hit       (hit[j])
            );
        end
        else
        begin : g_body
            mbps_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .shift     (shift),
                .clear     (clear),
                .byte_in   (byte_q[j-1]),
                .valid_in  (valid_q[j-1]),
                .pat       (pat[j]),
                .byte_out  (byte_q[j]),
                .valid_out (valid_q[j]),
                .hit       (hit[j])
            );
        end
    end

    // The window matches when every cell agrees
    assign match = &hit;

endmodule

// File: rtl/mbps_align.sv
// Pattern cells kept lined up with the window cells, turned one step a cycle on a length change.
module mbps_align (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr,
    input  logic [mbps_pkg::ENTRY_W-1:0]    idx,
    input  logic [mbps_pkg::BYTE_W-1:0]     value,
    input  logic                            care,
    input  logic [mbps_pkg::LEN_W-1:0]      len,
    output logic                            busy,
    output mbps_pkg::pat_ent_t              pat [mbps_pkg::MAX_PATTERN]
);
    import mbps_pkg::*;

    logic [BYTE_W-1:0]      val_reg [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] care_reg;
    logic [IDX_W-1:0]       pos_reg;
    logic [IDX_W-1:0]       target;
    logic [IDX_W-1:0]       wr_cell;
    logic [MAX_PATTERN-1:0] load_hit;
    logic                   grow;
    logic                   shrink;

    // Cell j holds pattern entry (pos - j) modulo MAX_PATTERN (a power of two):
    // cells 0..pos carry the pattern reversed, the others keep the unused entries
    assign target = IDX_W'(used_length(len) - LEN_W'(1));
    assign grow   = pos_reg < target;
    assign shrink = pos_reg > target;
    assign busy   = grow || shrink;

    // Find the cell that holds the loaded entry
    assign wr_cell = pos_reg - IDX_W'(idx);

    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
            load_hit[j] = wr && (32'(idx) < MAX_PATTERN) && (wr_cell == IDX_W'(j));
    end

    // Turn the pattern bytes one cell toward the new length, or write the loaded entry
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            if (grow)
                val_reg[IDX_W'(j)] <= val_reg[IDX_W'(j - 1)];
            else if (shrink)
                val_reg[IDX_W'(j)] <= val_reg[IDX_W'(j + 1)];
            else if (load_hit[j])
                val_reg[IDX_W'(j)] <= value;
        end
    end

    // Turn the care bits the same way and track the alignment
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            care_reg <= '0;
            pos_reg  <= '0;
        end
        else
        begin
            for (int j = 0; j < MAX_PATTERN; j++)
            begin
                if (grow)
                    care_reg[j] <= care_reg[IDX_W'(j - 1)];
                else if (shrink)
                    care_reg[j] <= care_reg[IDX_W'(j + 1)];
                else if (load_hit[j])
                    care_reg[j] <= care;
            end
            if (grow)
                pos_reg <= pos_reg + IDX_W'(1);
            else if (shrink)
                pos_reg <= pos_reg - IDX_W'(1);
        end
    end

    // Hand each window cell its pattern byte; entry 0 is always compared
    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            pat[j].value = val_reg[IDX_W'(j)];
            pat[j].cmp   = care_reg[j] || (IDX_W'(j) == pos_reg);
            pat[j].en    = (IDX_W'(j) <= pos_reg);
        end
    end

endmodule

// File: rtl/mbps_result.sv
// Result stage: tracks matches of the range and drives the result register.
`include "assert_macros.svh"

module mbps_result (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s1_valid,
    input  mbps_pkg::s1_t                   s1,
    input  logic signed [mbps_pkg::ADDR_W-1:0] result_offset,
    input  logic                            search_backward,
    output logic                            advance,
    mbps_out_if.source                      report
);
    import mbps_pkg::*;

    logic              seen_reg;
    logic              sent_reg;
    logic [ADDR_W-1:0] best_reg;
    logic              out_valid_reg;
    out_item_t         out_reg;

    logic              emit_fwd;
    logic              emit_end;
    logic              produce;
    logic              fire;
    logic              bwd_hit;
    logic              res_found;
    logic [ADDR_W-1:0] res_start;
    out_item_t         res;

    // Decide what this item produces
    assign bwd_hit  = s1.match && search_backward;
    assign emit_fwd = s1.match && !search_backward && !sent_reg;
    assign emit_end = s1.last && !sent_reg && !emit_fwd;
    assign produce  = s1_valid && (emit_fwd || emit_end);
    assign advance  = !produce || !out_valid_reg || report.ready;
    assign fire     = s1_valid && advance;

    // Pick the reported start and add the offset
    always_comb
    begin
        if (emit_fwd)
        begin
            res_found = 1'b1;
            res_start = s1.start;
        end
        else
        begin
            res_found = bwd_hit || seen_reg;
            res_start = bwd_hit ? s1.start : best_reg;
        end
        res.found         = res_found;
        res.match_address = res_found ? (res_start + $unsigned(result_offset)) : '0;
    end

    // Track the range
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
            sent_reg <= 1'b0;
            best_reg <= '0;
        end
        else if (fire)
        begin
            if (s1.last)
            begin
                seen_reg <= 1'b0;
                sent_reg <= 1'b0;
                best_reg <= '0;
            end
            else if (bwd_hit || emit_fwd)
            begin
                seen_reg <= 1'b1;
                best_reg <= s1.start;
                if (emit_fwd)
                    sent_reg <= 1'b1;
            end
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fire && produce)
            out_valid_reg <= 1'b1;
        else if (report.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fire && produce)
            out_reg <= res;
    end

    assign report.valid   = out_valid_reg;
    assign report.payload = out_reg;

    // A forward result always marks the range as having a match
    `ASSERT_SAME(a_sent_seen, clk, rst_n, sent_reg, seen_reg)
    // The end of a range leaves no match state behind
    `ASSERT_NEXT(a_end_clears, clk, rst_n, fire && s1.last, !seen_reg && !sent_reg && best_reg == '0)
    // A stall only comes from a full, untaken result register
    `ASSERT_SAME(a_stall_cause, clk, rst_n, !advance, out_valid_reg && !report.ready && produce)
    // A not-found result carries a zero address
    `ASSERT_SAME(a_nf_zero, clk, rst_n, out_valid_reg && !out_reg.found, out_reg.match_address == '0)

endmodule

// File: rtl/masked_byte_pattern_search_unit.sv
// Masked byte pattern search unit: register port, window chain and result stage.
//
// The unit takes one input item per clock while input is not held off. A load
// item writes one pattern entry; a stream item shifts its byte into a chain of
// MAX_PATTERN compare cells, each holding one window byte next to the pattern
// byte lined up with it, so the whole window is checked in the cycle the byte is
// taken. The compare outcome is registered and judged by the result stage in the
// next cycle, and a result leaves through an output register: a forward match or
// the end of a range shows up once it has passed the compare register and the
// output register. Input is held off while the result register is full and a
// further result is waiting behind it, and after a pattern length change while
// the pattern cells turn into the new alignment, one step of length at a time.
// After reset the unit is ready at once; no clearing pass runs. Registers:
// pattern length at 0x0, result offset at 0x4, search direction at 0x8; write
// them only while no result is pending.
module masked_byte_pattern_search_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    mbps_in_if.sink                             stream,
    mbps_out_if.source                          report,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mbps_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [mbps_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import mbps_pkg::*;

    logic                     cfg_wr;
    reg_idx_t                 cfg_idx;
    logic [LEN_W-1:0]         len_reg;
    logic [LEN_W-1:0]         len_next;
    logic signed [ADDR_W-1:0] offset_reg;
    logic                     backward_reg;

    logic                     in_accept;
    logic                     load_wr;
    logic                     stream_wr;
    logic                     match;
    logic                     advance;
    logic                     align_busy;
    logic                     s1_valid_reg;
    s1_t                      s1_reg;
    pat_ent_t                 pat [MAX_PATTERN];

    // Register port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    assign len_next = (cfg_wr && cfg_idx == REG_PATTERN_LENGTH) ?
                      pwdata[LEN_W-1:0] : len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= LEN_W'(1);
            offset_reg   <= '0;
            backward_reg <= 1'b0;
        end
        else
        begin
            len_reg <= len_next;
            if (cfg_wr && cfg_idx == REG_RESULT_OFFSET)
                offset_reg <= $signed(pwdata[ADDR_W-1:0]);
            if (cfg_wr && cfg_idx == REG_SEARCH_BACKWARD)
                backward_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_PATTERN_LENGTH:  prdata = CFG_DATA_W'(len_reg);
            REG_RESULT_OFFSET:   prdata = CFG_DATA_W'($unsigned(offset_reg));
            REG_SEARCH_BACKWARD: prdata = CFG_DATA_W'(backward_reg);
            default:             prdata = '0;
        endcase
    end

    // Input handshake; hold off while the pattern is being realigned or the result stage stalls
    assign stream.ready = !align_busy && (!s1_valid_reg || advance);
    assign in_accept    = stream.valid && stream.ready;
    assign load_wr      = in_accept && (stream.payload.mode == MODE_LOAD);
    assign stream_wr    = in_accept && (stream.payload.mode == MODE_STREAM);

    mbps_align u_align (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (load_wr),
        .idx      (stream.payload.entry_index),
        .value    (stream.payload.byte_value),
        .care     (stream.payload.care),
        .len      (len_reg),
        .busy     (align_busy),
        .pat      (pat)
    );

    mbps_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift    (stream_wr),
        .clear    (stream.payload.last),
        .new_byte (stream.payload.byte_value),
        .pat      (pat),
        .match    (match)
    );

    // Register the compare outcome of a streamed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (stream_wr)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (stream_wr)
        begin
            s1_reg.match <= match;
            s1_reg.last  <= stream.payload.last;
            s1_reg.start <= stream.payload.byte_address -
                            ADDR_W'(used_length(len_reg) - LEN_W'(1));
        end
    end

    mbps_result u_result (
        .clk             (clk),
        .rst_n           (rst_n),
        .s1_valid        (s1_valid_reg),
        .s1              (s1_reg),
        .result_offset   (offset_reg),
        .search_backward (backward_reg),
        .advance         (advance),
        .report          (report)
    );

endmodule
